### hw/rtl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants for the byte move-to-front codec.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int DATA_W     = 8;
  localparam int GROUP_SIZE = 16;
  localparam int LOCAL_W    = 4;

  // Operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Encode result for a byte that is not in the list
  localparam logic [DATA_W-1:0] ABSENT_CODE = 8'hFF;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // take the input item, reload identity order if first
    logic match;     // register per-entry hit vector
    logic group;     // register per-group hit, local position and value
    logic select;    // register final position, value and found flag
    logic move;      // write the result and rotate the list
  } cmd_t;

endpackage

### hw/rtl/mtf_sym_if.sv
// ----------------------------------------------------------------------------
// mtf_sym_if
// Input channel of the codec: one operation per item.
// ----------------------------------------------------------------------------
interface mtf_sym_if;
  import mtf_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] data_in;
  logic              first;
  logic              last;

  modport source (output valid, op, data_in, first, last, input ready);
  modport sink   (input valid, op, data_in, first, last, output ready);

endinterface

### hw/rtl/mtf_res_if.sv
// ----------------------------------------------------------------------------
// mtf_res_if
// Output channel of the codec: one result per item.
// ----------------------------------------------------------------------------
interface mtf_res_if;
  import mtf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              last_out;

  modport source (output valid, data_out, last_out, input ready);
  modport sink   (input valid, data_out, last_out, output ready);

endinterface

### hw/rtl/mtf_ctrl.sv
// ----------------------------------------------------------------------------
// mtf_ctrl
// Sequencer: steps each item through match, group reduce, select and move,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module mtf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mtf_pkg::cmd_t cmd
);
  import mtf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_SELECT,
    S_MOVE
  } state_t;

  state_t state;
  logic   slot_free;

  // No item is taken while reset is held
  assign in_ready  = (state == S_IDLE) && !rst;
  assign slot_free = !out_valid || out_ready;

  // Command decode
  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.match   = (state == S_MATCH);
    cmd.group   = (state == S_GROUP);
    cmd.select  = (state == S_SELECT);
    cmd.move    = (state == S_MOVE) && slot_free;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:   if (in_valid) state <= S_MATCH;
        S_MATCH:  state <= S_GROUP;
        S_GROUP:  state <= S_SELECT;
        S_SELECT: state <= S_MOVE;
        S_MOVE:   if (slot_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/mtf_datapath.sv
// ----------------------------------------------------------------------------
// mtf_datapath
// Symbol list held in a row of registers, parallel compare, two-level
// registered reduction to position and value, and the front rotation.
// ----------------------------------------------------------------------------
module mtf_datapath #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mtf_pkg::cmd_t              cmd,
  input  logic                       op,
  input  logic [mtf_pkg::DATA_W-1:0] data_in,
  input  logic                       first,
  input  logic                       last,
  output logic [mtf_pkg::DATA_W-1:0] data_out,
  output logic                       last_out
);
  import mtf_pkg::*;

  localparam int N  = ALPHABET_SIZE;
  localparam int NG = (N + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NC = NG * GROUP_SIZE;
  localparam logic [DATA_W:0] SIZE_W = (DATA_W + 1)'(N);
  localparam logic [DATA_W:0] TAIL_W = (DATA_W + 1)'(N - 1);

  logic [DATA_W-1:0]  cells [N];
  logic [DATA_W-1:0]  cell_pad [NC];

  logic               op_q;
  logic [DATA_W-1:0]  d_q;
  logic               last_q;
  logic [DATA_W-1:0]  d_sat;

  logic [NC-1:0]      hit;
  logic [NC-1:0]      hit_next;

  logic [NG-1:0]      grp_any;
  logic [NG-1:0]      grp_any_next;
  logic [LOCAL_W-1:0] grp_pos [NG];
  logic [LOCAL_W-1:0] grp_pos_next [NG];
  logic [DATA_W-1:0]  grp_val [NG];
  logic [DATA_W-1:0]  grp_val_next [NG];

  logic               sel_found;
  logic               sel_found_next;
  logic [DATA_W-1:0]  sel_pos;
  logic [DATA_W-1:0]  sel_pos_next;
  logic [DATA_W-1:0]  sel_val;
  logic [DATA_W-1:0]  sel_val_next;

  // Decode positions past the tail saturate to the tail
  assign d_sat = ({1'b0, d_q} >= SIZE_W) ? TAIL_W[DATA_W-1:0] : d_q;

  // Per-entry compare, padded to whole groups
  for (genvar gi = 0; gi < NC; gi++) begin : g_cell
    if (gi < N) begin : g_real
      assign cell_pad[gi] = cells[gi];
      assign hit_next[gi] = (op_q == OP_DECODE) ? (d_sat == DATA_W'(gi))
                                                 : (cells[gi] == d_q);
    end else begin : g_pad
      assign cell_pad[gi] = '0;
      assign hit_next[gi] = 1'b0;
    end
  end

  // First level: reduce each group of entries (at most one hit overall)
  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      grp_any_next[g] = 1'b0;
      grp_pos_next[g] = '0;
      grp_val_next[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (hit[g*GROUP_SIZE + j]) begin
          grp_any_next[g] = 1'b1;
          grp_pos_next[g] = grp_pos_next[g] | LOCAL_W'(j);
          grp_val_next[g] = grp_val_next[g] | cell_pad[g*GROUP_SIZE + j];
        end
      end
    end
  end

  // Second level: pick the group that holds the hit
  always_comb begin
    sel_found_next = 1'b0;
    sel_pos_next   = '0;
    sel_val_next   = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp_any[g]) begin
        sel_found_next = 1'b1;
        sel_pos_next   = sel_pos_next | DATA_W'(g * GROUP_SIZE)
                                      | DATA_W'(grp_pos[g]);
        sel_val_next   = sel_val_next | grp_val[g];
      end
    end
  end

  // Pipeline of the item through the reduction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      d_q    <= data_in;
      last_q <= last;
    end
    if (cmd.match) begin
      hit <= hit_next;
    end
    if (cmd.group) begin
      grp_any <= grp_any_next;
      grp_pos <= grp_pos_next;
      grp_val <= grp_val_next;
    end
    if (cmd.select) begin
      sel_found <= sel_found_next;
      sel_pos   <= sel_pos_next;
      sel_val   <= sel_val_next;
    end
    if (cmd.move) begin
      last_out <= last_q;
      if (op_q == OP_DECODE) begin
        data_out <= sel_val;
      end else begin
        data_out <= sel_found ? sel_pos : ABSENT_CODE;
      end
    end
  end

  // Symbol list: identity on reset or first item, rotate on move when found
  always_ff @(posedge clk) begin
    if (rst || (cmd.capture && first)) begin
      for (int i = 0; i < N; i++) begin
        cells[i] <= DATA_W'(i);
      end
    end else if (cmd.move && sel_found) begin
      cells[0] <= sel_val;
      for (int i = 1; i < N; i++) begin
        if (DATA_W'(i) <= sel_pos) begin
          cells[i] <= cells[i-1];
        end
      end
    end
  end

endmodule

### hw/rtl/move_to_front_codec_top.sv
// Item flow: accepted in idle, then the compare, two-level reduce, select
//   and rotate steps run in turn on the one symbol list; the next item is
//   accepted only after the result is written.
// Reset (rst, synchronous): list back to identity order, output empty.
// An item flagged first reloads identity order in its accept cycle.
// ----------------------------------------------------------------------------
// move_to_front_codec_top
// Byte move-to-front encoder and decoder over an ordered symbol list.
// ----------------------------------------------------------------------------
module move_to_front_codec_top #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst,
  mtf_sym_if.sink    feed,
  mtf_res_if.source  result
);
  import mtf_pkg::*;

  cmd_t cmd;

  mtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (feed.valid),
    .in_ready  (feed.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  mtf_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op       (feed.op),
    .data_in  (feed.data_in),
    .first    (feed.first),
    .last     (feed.last),
    .data_out (result.data_out),
    .last_out (result.last_out)
  );

endmodule
